// ===== rtl/cbst_pkg.sv =====
// ----------------------------------------------------------------------------
// cbst_pkg
// Shared types and constants for the CBOR stream tokenizer.
// ----------------------------------------------------------------------------
package cbst_pkg;

  localparam int unsigned MAX_DEPTH = 16;
  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned REM_W = 33;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NEGINT = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_TAG    = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  localparam logic [4:0] INFO_FALSE = 5'd20;
  localparam logic [4:0] INFO_UNDEF = 5'd23;
  localparam logic [4:0] INFO_ARG1  = 5'd24;
  localparam logic [4:0] INFO_ARG8  = 5'd27;
  localparam logic [4:0] INFO_RSV   = 5'd28;

  localparam logic [3:0] EV_UINT   = 4'd0;
  localparam logic [3:0] EV_NEGINT = 4'd1;
  localparam logic [3:0] EV_BHDR   = 4'd2;
  localparam logic [3:0] EV_BDATA  = 4'd3;
  localparam logic [3:0] EV_THDR   = 4'd4;
  localparam logic [3:0] EV_TDATA  = 4'd5;
  localparam logic [3:0] EV_ARRAY  = 4'd6;
  localparam logic [3:0] EV_MAP    = 4'd7;
  localparam logic [3:0] EV_TAG    = 4'd8;
  localparam logic [3:0] EV_SIMPLE = 4'd9;
  localparam logic [3:0] EV_FALSE  = 4'd10;
  localparam logic [3:0] EV_OK     = 4'd14;
  localparam logic [3:0] EV_ERROR  = 4'd15;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RSV      = 3'd1;
  localparam logic [2:0] ERR_LEN8     = 3'd2;
  localparam logic [2:0] ERR_KEY      = 3'd3;
  localparam logic [2:0] ERR_EXTRA    = 3'd4;
  localparam logic [2:0] ERR_DEEP     = 3'd5;
  localparam logic [2:0] ERR_EMPTY    = 3'd6;
  localparam logic [2:0] ERR_UNFINISH = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ARG,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [63:0] argument;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [4:0]  nest_depth;
    logic        top_complete;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] major;
    logic [4:0] minor;
    logic       rsv;
    logic       len8;
    logic       has_arg;
    logic [3:0] arg_len;
  } cls_t;

endpackage

// ===== rtl/cbst_front.sv =====
// ----------------------------------------------------------------------------
// cbst_front
// Input queue: accepts words, splits the initial-byte fields and holds up to
// two classified words for the engine.
// ----------------------------------------------------------------------------
module cbst_front import cbst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     cls_valid_o,
  output cls_t     cls_o,
  input  logic     cls_take_i
);

  cls_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cls_t       cls_new;
  logic       do_push, do_pop;

  always_comb begin
    cls_new.kind      = in_item_i.kind;
    cls_new.data_byte = in_item_i.data_byte;
    cls_new.major     = in_item_i.data_byte[7:5];
    cls_new.minor     = in_item_i.data_byte[4:0];
    cls_new.rsv       = (in_item_i.data_byte[4:0] >= INFO_RSV);
    cls_new.len8      = (in_item_i.data_byte[4:0] == INFO_ARG8) &&
                        (in_item_i.data_byte[7:5] >= MT_BYTES) &&
                        (in_item_i.data_byte[7:5] <= MT_MAP);
    cls_new.has_arg   = (in_item_i.data_byte[4:0] >= INFO_ARG1);
    cls_new.arg_len   = 4'd1 << in_item_i.data_byte[1:0];
  end

  assign full        = (cnt_q == 2'd2);
  assign cls_valid_o = (cnt_q != 2'd0);
  assign cls_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cls_take_i && cls_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls_new;
    end
  end

endmodule

// ===== rtl/cbst_back.sv =====
// ----------------------------------------------------------------------------
// cbst_back
// Decode engine: argument collection, payload pass-through, nesting stack,
// error checks and the result register.
// ----------------------------------------------------------------------------
module cbst_back import cbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cls_valid_i,
  input  cls_t      cls_i,
  output logic      cls_take_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  phase_e             phase_q, phase_d;
  logic [2:0]         major_q, major_d;
  logic [4:0]         minor_q, minor_d;
  logic [3:0]         argleft_q, argleft_d;
  logic [63:0]        acc_q, acc_d;
  logic [31:0]        payleft_q, payleft_d;
  logic [DEPTH_W-1:0] sp_q, sp_d;
  logic [REM_W-1:0]   top_rem_q, top_rem_d;
  logic               top_map_q, top_map_d;
  logic               have_q, have_d;
  logic               err_q, err_d;
  logic [2:0]         code_q, code_d;
  logic [REM_W-1:0]   lvl_rem_q [MAX_DEPTH];
  logic               lvl_map_q [MAX_DEPTH];
  out_item_t          out_q;
  logic               out_valid_q;

  logic               step;
  logic               emit;
  logic [3:0]         r_ev;
  logic [63:0]        r_arg;
  logic [7:0]         r_pb;
  logic               r_last, r_done;
  logic [2:0]         r_code;
  logic [DEPTH_W-1:0] r_depth;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx, rd_idx;
  logic [REM_W-1:0]   wr_rem;
  logic               wr_map;
  out_item_t          res;

  logic               fin, plc, fail;
  logic [2:0]         fin_major, fail_code;
  logic [4:0]         fin_minor;
  logic [63:0]        fin_val;
  logic [31:0]        fin_v32;
  logic [3:0]         p_ev;
  logic [63:0]        p_arg;
  logic [7:0]         p_pb;
  logic               p_last, p_open, p_map, popped;
  logic [REM_W-1:0]   p_slots, rem_dec;
  logic [DEPTH_W-1:0] sp_a;
  logic [3:0]         al_dec;
  logic [31:0]        pl_dec;

  assign step       = cls_valid_i && (!out_valid_q || pop);
  assign cls_take_o = step;
  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_comb begin
    phase_d = phase_q; major_d = major_q; minor_d = minor_q;
    argleft_d = argleft_q; acc_d = acc_q; payleft_d = payleft_q;
    sp_d = sp_q; top_rem_d = top_rem_q; top_map_d = top_map_q;
    have_d = have_q; err_d = err_q; code_d = code_q;
    emit = 1'b0; r_ev = EV_OK; r_arg = '0; r_pb = '0; r_last = 1'b0;
    r_done = 1'b0; r_code = ERR_NONE; r_depth = sp_q;
    wr_en = 1'b0; wr_idx = '0; wr_rem = '0; wr_map = 1'b0;
    fin = 1'b0; plc = 1'b0; fail = 1'b0; fail_code = ERR_NONE;
    fin_major = major_q; fin_minor = minor_q; fin_val = '0; fin_v32 = '0;
    p_ev = EV_UINT; p_arg = '0; p_pb = '0; p_last = 1'b0; p_open = 1'b0;
    p_map = 1'b0; p_slots = '0; popped = 1'b0; sp_a = sp_q;
    rem_dec = (top_rem_q != '0) ? top_rem_q - REM_W'(1) : top_rem_q;
    rd_idx = IDX_W'(sp_q - DEPTH_W'(2));
    al_dec = (argleft_q != 4'd0) ? argleft_q - 4'd1 : argleft_q;
    pl_dec = (payleft_q != 32'd0) ? payleft_q - 32'd1 : payleft_q;

    if (cls_i.kind == KIND_END) begin
      emit = 1'b1;
      r_ev = EV_ERROR;
      if (err_q) begin
        r_code = code_q;
      end else if (phase_q != PH_HEADER || sp_q != '0) begin
        r_code = ERR_UNFINISH;
      end else if (!have_q) begin
        r_code = ERR_EMPTY;
      end else begin
        r_ev = EV_OK;
      end
      phase_d = PH_HEADER; major_d = '0; minor_d = '0; argleft_d = '0;
      acc_d = '0; payleft_d = '0; sp_d = '0; have_d = 1'b0;
      err_d = 1'b0; code_d = ERR_NONE;
    end else if (!err_q) begin
      unique case (phase_q)
        PH_ARG: begin
          acc_d = {acc_q[55:0], cls_i.data_byte};
          argleft_d = al_dec;
          if (al_dec == 4'd0) begin
            fin = 1'b1;
            fin_val = acc_d;
          end
        end
        PH_PAYLOAD: begin
          payleft_d = pl_dec;
          p_ev = (major_q == MT_BYTES) ? EV_BDATA : EV_TDATA;
          p_pb = cls_i.data_byte;
          if (pl_dec == 32'd0) begin
            phase_d = PH_HEADER;
            plc = 1'b1;
            p_last = 1'b1;
          end else begin
            emit = 1'b1; r_ev = p_ev; r_pb = cls_i.data_byte;
          end
        end
        default: begin
          if (cls_i.rsv) begin
            fail = 1'b1; fail_code = ERR_RSV;
          end else if (cls_i.len8) begin
            fail = 1'b1; fail_code = ERR_LEN8;
          end else if (sp_q == '0 && have_q) begin
            fail = 1'b1; fail_code = ERR_EXTRA;
          end else if (sp_q != '0 && top_map_q && !top_rem_q[0] &&
                       cls_i.major != MT_TEXT) begin
            fail = 1'b1; fail_code = ERR_KEY;
          end else begin
            major_d = cls_i.major;
            minor_d = cls_i.minor;
            if (cls_i.has_arg) begin
              argleft_d = cls_i.arg_len;
              acc_d = '0;
              phase_d = PH_ARG;
            end else begin
              fin = 1'b1;
              fin_major = cls_i.major;
              fin_minor = cls_i.minor;
              fin_val = 64'(cls_i.minor);
            end
          end
        end
      endcase
    end

    if (fin) begin
      phase_d = PH_HEADER;
      fin_v32 = fin_val[31:0];
      plc = 1'b1;
      p_arg = fin_val;
      case (fin_major)
        MT_UINT:   p_ev = EV_UINT;
        MT_NEGINT: p_ev = EV_NEGINT;
        MT_BYTES, MT_TEXT: begin
          p_ev = (fin_major == MT_BYTES) ? EV_BHDR : EV_THDR;
          if (fin_val != 64'd0) begin
            plc = 1'b0;
            payleft_d = fin_v32;
            phase_d = PH_PAYLOAD;
            emit = 1'b1; r_ev = p_ev; r_arg = fin_val;
          end
        end
        MT_ARRAY: begin
          p_ev = EV_ARRAY; p_arg = 64'(fin_v32);
          p_open = (fin_v32 != 32'd0); p_slots = REM_W'(fin_v32);
        end
        MT_MAP: begin
          p_ev = EV_MAP; p_arg = 64'(fin_v32);
          p_open = (fin_v32 != 32'd0); p_slots = {fin_v32, 1'b0}; p_map = 1'b1;
        end
        MT_TAG: p_ev = EV_TAG;
        default: begin
          if (fin_minor >= INFO_FALSE && fin_minor <= INFO_UNDEF) begin
            p_ev = EV_FALSE + 4'(fin_minor[1:0]);
            p_arg = '0;
          end else begin
            p_ev = EV_SIMPLE;
          end
        end
      endcase
    end

    if (plc) begin
      if (sp_q == '0) begin
        have_d = 1'b1;
        r_done = !p_open;
      end else begin
        top_rem_d = rem_dec;
        if (rem_dec == '0) begin
          popped = 1'b1;
          sp_a = sp_q - DEPTH_W'(1);
          r_done = (sp_a == '0) && !p_open;
          top_rem_d = lvl_rem_q[rd_idx];
          top_map_d = lvl_map_q[rd_idx];
        end
      end
      sp_d = sp_a;
      if (p_open) begin
        if (sp_a >= DEPTH_W'(MAX_DEPTH)) begin
          fail = 1'b1; fail_code = ERR_DEEP; r_depth = sp_a;
        end else begin
          if (!popped && sp_q != '0) begin
            wr_en = 1'b1;
            wr_idx = IDX_W'(sp_q - DEPTH_W'(1));
            wr_rem = rem_dec;
            wr_map = top_map_q;
          end
          top_rem_d = p_slots;
          top_map_d = p_map;
          sp_d = sp_a + DEPTH_W'(1);
        end
      end
      if (!fail) begin
        emit = 1'b1; r_ev = p_ev; r_arg = p_arg; r_pb = p_pb;
        r_last = p_last; r_depth = sp_d;
      end
    end

    if (fail) begin
      err_d = 1'b1; code_d = fail_code; phase_d = PH_HEADER;
      emit = 1'b1; r_ev = EV_ERROR; r_arg = '0; r_pb = '0; r_last = 1'b0;
      r_done = 1'b0; r_code = fail_code; r_depth = sp_a;
    end
  end

  always_comb begin
    res.event_res    = r_ev;
    res.argument     = r_arg;
    res.payload_byte = r_pb;
    res.payload_last = r_last;
    res.nest_depth   = 5'(r_depth);
    res.top_complete = r_done;
    res.error_code   = r_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; major_q <= '0; minor_q <= '0; argleft_q <= '0;
      acc_q <= '0; payleft_q <= '0; sp_q <= '0; top_rem_q <= '0;
      top_map_q <= 1'b0; have_q <= 1'b0; err_q <= 1'b0; code_q <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; major_q <= major_d; minor_q <= minor_d;
        argleft_q <= argleft_d; acc_q <= acc_d; payleft_q <= payleft_d;
        sp_q <= sp_d; top_rem_q <= top_rem_d; top_map_q <= top_map_d;
        have_q <= have_d; err_q <= err_d; code_q <= code_d;
      end
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= res;
    end
    if (step && wr_en) begin
      lvl_rem_q[wr_idx] <= wr_rem;
      lvl_map_q[wr_idx] <= wr_map;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= DEPTH_W'(MAX_DEPTH)) else $error("stack depth out of range");

  a_arg_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ARG |-> argleft_q != 4'd0) else $error("argument phase with no bytes left");

  a_err_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit && r_ev == EV_ERROR && cls_i.kind == KIND_BYTE |=> err_q)
    else $error("stream error not latched");

  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.event_res == EV_ERROR) == (out_q.error_code != ERR_NONE)))
    else $error("error code and event disagree");

endmodule

// ===== rtl/cbor_stream_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// cbor_stream_tokenizer_top
// CBOR byte-stream tokenizer: a token per data item, per string payload byte and per end-of-stream marker.
//
// Input side is a queue: drive in_item_i and raise push while full is low.
// Each word is a stream byte, or an end-of-stream marker that runs the final
// check and returns the block to its reset state.
// Output side is a queue: while empty is low the oldest token is on
// out_item_o; raise pop to take it.
// A two-word input queue feeds the decode engine, which handles one word per
// cycle unless held by the result register. A pushed word is stored in the
// input queue, then taken by an idle engine into the result register that
// drives out_item_o. With pop held high the block takes one word per cycle.
// Argument bytes before the last, and stream bytes after an error, give no
// token. The engine takes a new word only when the result register is free
// or being popped, so a stalled receiver fills the input queue and raises
// full.
// Nesting stack: 16 levels; one level closes per word.
// Reset (rst_ni low) empties both queues and clears the decoder state.
// ----------------------------------------------------------------------------
module cbor_stream_tokenizer_top import cbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic cls_valid, cls_take;
  cls_t cls;

  cbst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_take_i  (cls_take)
  );

  cbst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_take_o  (cls_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/cbor_stream_tokenizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// cbor_stream_tokenizer_top_tb
// Self-checking bench for the CBOR stream tokenizer. A queue of stream words
// (directed corner cases, then random well-formed documents with some noise)
// feeds a push-side driver; a token predictor fills a queue of expected
// tokens, and a pop-side monitor checks each token field by field.
// ----------------------------------------------------------------------------
module cbor_stream_tokenizer_top_tb;
  import cbst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  in_item_t  words_pending[$];
  out_item_t tokens_expected[$];
  bit        failed;
  bit        calm;
  bit        hold_send;
  bit        in_taken;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned pop_gap;

  // predictor state
  phase_e      pr_phase;
  logic [2:0]  pr_major;
  logic [4:0]  pr_minor;
  logic [3:0]  pr_arg_left;
  logic [63:0] pr_accum;
  logic [31:0] pr_pay_left;
  logic [32:0] pr_remain[MAX_DEPTH];
  logic        pr_is_map[MAX_DEPTH];
  int unsigned pr_top;
  bit          pr_have_item;
  bit          pr_err;
  logic [2:0]  pr_code;

  cbor_stream_tokenizer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic clear_tokenizer();
    pr_phase = PH_HEADER;
    pr_major = '0;
    pr_minor = '0;
    pr_arg_left = '0;
    pr_accum = '0;
    pr_pay_left = '0;
    pr_top = 0;
    pr_have_item = 0;
    pr_err = 0;
    pr_code = ERR_NONE;
  endtask

  task automatic add_token(logic [3:0] ev, logic [63:0] arg, logic [7:0] pb, logic pl,
                           logic done, logic [2:0] code);
    out_item_t t;
    t.event_res = ev;
    t.argument = arg;
    t.payload_byte = pb;
    t.payload_last = pl;
    t.nest_depth = pr_top[4:0];
    t.top_complete = done;
    t.error_code = code;
    tokens_expected.insert(tokens_expected.size(), t);
  endtask

  task automatic raise_error(logic [2:0] code);
    pr_err = 1;
    pr_code = code;
    pr_phase = PH_HEADER;
    add_token(EV_ERROR, '0, '0, 1'b0, 1'b0, code);
  endtask

  task automatic place_item(logic [3:0] ev, logic [63:0] arg, logic [7:0] pb, logic pl,
                            bit opens, logic [32:0] slots, bit is_map);
    bit done;
    done = 0;
    if (pr_top == 0) begin
      pr_have_item = 1;
      if (!opens) done = 1;
    end else begin
      if (pr_remain[pr_top-1] > 0) pr_remain[pr_top-1]--;
      if (pr_remain[pr_top-1] == 0) begin
        pr_top--;
        if (pr_top == 0 && !opens) done = 1;
      end
    end
    if (opens) begin
      if (pr_top >= MAX_DEPTH) begin
        raise_error(ERR_DEEP);
        return;
      end
      pr_remain[pr_top] = slots;
      pr_is_map[pr_top] = is_map;
      pr_top++;
    end
    add_token(ev, arg, pb, pl, done, ERR_NONE);
  endtask

  task automatic close_header(logic [63:0] value);
    logic [63:0] v32;
    pr_phase = PH_HEADER;
    v32 = {32'd0, value[31:0]};
    case (pr_major)
      MT_UINT:   place_item(EV_UINT, value, '0, 1'b0, 0, '0, 0);
      MT_NEGINT: place_item(EV_NEGINT, value, '0, 1'b0, 0, '0, 0);
      MT_BYTES, MT_TEXT: begin
        if (value == 0) begin
          place_item((pr_major == MT_BYTES) ? EV_BHDR : EV_THDR, '0, '0, 1'b0, 0, '0, 0);
        end else begin
          pr_pay_left = value[31:0];
          pr_phase = PH_PAYLOAD;
          add_token((pr_major == MT_BYTES) ? EV_BHDR : EV_THDR, value, '0, 1'b0, 1'b0,
                    ERR_NONE);
        end
      end
      MT_ARRAY: place_item(EV_ARRAY, v32, '0, 1'b0, v32 != 0, v32[32:0], 0);
      MT_MAP:   place_item(EV_MAP, v32, '0, 1'b0, v32 != 0, {v32[31:0], 1'b0}, 1);
      MT_TAG:   place_item(EV_TAG, value, '0, 1'b0, 0, '0, 0);
      default: begin
        if (pr_minor >= INFO_FALSE && pr_minor <= INFO_UNDEF)
          place_item(EV_FALSE + 4'(pr_minor - INFO_FALSE), '0, '0, 1'b0, 0, '0, 0);
        else
          place_item(EV_SIMPLE, value, '0, 1'b0, 0, '0, 0);
      end
    endcase
  endtask

  task automatic predict_tokens(in_item_t w);
    logic [2:0] mj;
    logic [4:0] mn;
    mj = w.data_byte[7:5];
    mn = w.data_byte[4:0];
    if (w.kind == KIND_END) begin
      if (pr_err) add_token(EV_ERROR, '0, '0, 1'b0, 1'b0, pr_code);
      else if (pr_phase != PH_HEADER || pr_top != 0)
        add_token(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_UNFINISH);
      else if (!pr_have_item) add_token(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_EMPTY);
      else add_token(EV_OK, '0, '0, 1'b0, 1'b0, ERR_NONE);
      clear_tokenizer();
      return;
    end
    if (pr_err) return;
    if (pr_phase == PH_ARG) begin
      pr_accum = {pr_accum[55:0], w.data_byte};
      if (pr_arg_left > 0) pr_arg_left--;
      if (pr_arg_left == 0) close_header(pr_accum);
      return;
    end
    if (pr_phase == PH_PAYLOAD) begin
      if (pr_pay_left > 0) pr_pay_left--;
      if (pr_pay_left == 0) begin
        pr_phase = PH_HEADER;
        place_item((pr_major == MT_BYTES) ? EV_BDATA : EV_TDATA, '0, w.data_byte, 1'b1,
                   0, '0, 0);
      end else begin
        add_token((pr_major == MT_BYTES) ? EV_BDATA : EV_TDATA, '0, w.data_byte, 1'b0,
                  1'b0, ERR_NONE);
      end
      return;
    end
    if (mn >= INFO_RSV) raise_error(ERR_RSV);
    else if (mn == INFO_ARG8 && mj >= MT_BYTES && mj <= MT_MAP) raise_error(ERR_LEN8);
    else if (pr_top == 0 && pr_have_item) raise_error(ERR_EXTRA);
    else if (pr_top > 0 && pr_is_map[pr_top-1] && !pr_remain[pr_top-1][0] && mj != MT_TEXT)
      raise_error(ERR_KEY);
    else begin
      pr_major = mj;
      pr_minor = mn;
      if (mn >= INFO_ARG1) begin
        pr_arg_left = 4'(1 << (mn - INFO_ARG1));
        pr_accum = '0;
        pr_phase = PH_ARG;
      end else begin
        close_header({59'd0, mn});
      end
    end
  endtask

  function automatic in_item_t mk(logic k, logic [7:0] b);
    in_item_t w;
    w.kind = k;
    w.data_byte = b;
    return w;
  endfunction

  task automatic put(logic [7:0] b);
    words_pending.insert(words_pending.size(), mk(KIND_BYTE, b));
  endtask

  task automatic put_end();
    words_pending.insert(words_pending.size(), mk(KIND_END, 8'h00));
  endtask

  // header with a random argument encoding for the given value
  task automatic put_head(logic [2:0] mj, logic [31:0] value);
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (value < 24 && sel == 0) put({mj, value[4:0]});
    else if (value < 256 && sel <= 1) begin put({mj, 5'd24}); put(value[7:0]); end
    else if (value < 65536 && sel <= 2) begin
      put({mj, 5'd25}); put(value[15:8]); put(value[7:0]);
    end else begin
      put({mj, 5'd26}); put(value[31:24]); put(value[23:16]); put(value[15:8]);
      put(value[7:0]);
    end
  endtask

  task automatic put_string(logic [2:0] mj, int unsigned len);
    put_head(mj, len);
    repeat (len) put(8'($urandom));
  endtask

  task automatic put_value(int unsigned lvl);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, (lvl >= 5) ? 5 : 8);
    case (pick)
      0: put_head(MT_UINT, $urandom);
      1: put_head(MT_NEGINT, $urandom_range(0, 300));
      2: put_string(MT_BYTES, $urandom_range(0, 4));
      3: put_string(MT_TEXT, $urandom_range(0, 4));
      4: put({MT_SIMPLE, 5'($urandom_range(0, 23))});
      5: begin
        put({MT_UINT, 5'd27});
        repeat (8) put(8'($urandom));
      end
      6: begin
        n = $urandom_range(0, 3);
        put_head(MT_ARRAY, n);
        repeat (n) put_value(lvl + 1);
      end
      7: begin
        n = $urandom_range(0, 2);
        put_head(MT_MAP, n);
        repeat (n) begin
          put_string(MT_TEXT, $urandom_range(0, 2));
          put_value(lvl + 1);
        end
      end
      default: begin
        put_head(MT_TAG, $urandom_range(0, 70000));
        put_value(lvl + 1);
      end
    endcase
  endtask

  initial begin
    int unsigned r;
    failed = 0;
    calm = 0;
    hold_send = 0;
    cycle_count = 0;
    clear_tokenizer();
    // extremes, simple values and error cases
    put(8'h00); put_end();
    put({MT_UINT, 5'd27}); repeat (8) put(8'hFF); put_end();
    put({MT_NEGINT, 5'd23}); put_end();
    put({MT_SIMPLE, 5'd21}); put(8'h00); put_end();
    put({MT_SIMPLE, 5'd24}); put(8'hFF); put_end();
    put_end();
    put({MT_TEXT, 5'd28}); put_end();
    put({MT_MAP, 5'd27}); put_end();
    put({MT_MAP, 5'd1}); put(8'h01); put_end();
    put({MT_ARRAY, 5'd2}); put(8'h00); put_end();
    put({MT_BYTES, 5'd2}); put(8'hAA); put(8'h55); put({MT_TAG, 5'd1}); put_end();
    put({MT_TAG, 5'd2}); put({MT_ARRAY, 5'd0}); put_end();
    put({MT_MAP, 5'd0}); put_end();
    repeat (17) put({MT_ARRAY, 5'd2});
    put_end();
    while (words_pending.size() < 800) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 6)) put(8'($urandom));
      end else if (r == 1) begin
        put_value(0);
        words_pending.delete(words_pending.size() - 1);
      end else begin
        put_value(0);
      end
      put_end();
    end
    hold_send = 1;
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && push && !full;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_item_i <= '0;
      send_gap <= 0;
    end else begin
      if (in_taken) begin
        predict_tokens(in_item_i);
        void'(words_pending.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (words_pending.size() == 0 || (hold_send == 1 &&
                   words_pending.size() < 400 && tokens_expected.size() != 0)) begin
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(1, 8);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_item_i <= words_pending[0];
      end
      if (hold_send && words_pending.size() < 400 && tokens_expected.size() == 0)
        hold_send = 0;
      calm <= words_pending.size() < 120;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop_gap <= $urandom_range(1, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_tok;
    if (rst_ni && pop && !empty) begin
      if (tokens_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_item_o);
        failed = 1;
      end else begin
        exp_tok = tokens_expected.pop_front();
        if (out_item_o.event_res !== exp_tok.event_res ||
            out_item_o.argument !== exp_tok.argument ||
            out_item_o.payload_byte !== exp_tok.payload_byte ||
            out_item_o.payload_last !== exp_tok.payload_last ||
            out_item_o.nest_depth !== exp_tok.nest_depth ||
            out_item_o.top_complete !== exp_tok.top_complete ||
            out_item_o.error_code !== exp_tok.error_code) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_tok, out_item_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** cbor_stream_tokenizer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (words_pending.size() == 0 && push == 1'b0);
    wait (tokens_expected.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed && tokens_expected.size() == 0) begin
      $display("** cbor_stream_tokenizer_top: PASSED **");
    end else begin
      $display("** cbor_stream_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule
